// ===== design/light_bar_pair_scorer_assert.svh =====
// Assertion macros for the checker file.
`ifndef LIGHT_BAR_PAIR_SCORER_ASSERT_SVH
`define LIGHT_BAR_PAIR_SCORER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LBPS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbps assertion failed");

// Next-cycle implication.
`define LBPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbps assertion failed");

`endif

// ===== design/lbps_pkg.sv =====
`default_nettype none

package lbps_pkg;

  // quotient bits per divider; one pipeline cell per bit
  localparam int unsigned QUO_W     = 29;
  localparam int unsigned ANG_DEN_W = 14;
  localparam int unsigned LEN_DEN_W = 19;
  localparam int unsigned VRT_DEN_W = 33;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LIMIT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_RATIO_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_RATIO_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIDENCE_FLOOR  = 3'd3;

  localparam logic [10:0] ANGLE_LIMIT_RST       = 11'd160;
  localparam logic [11:0] SPACING_RATIO_MIN_RST = 12'd256;
  localparam logic [11:0] SPACING_RATIO_MAX_RST = 12'd768;
  localparam logic [10:0] CONFIDENCE_FLOOR_RST  = 11'd512;

  localparam logic signed [12:0] FOLD_SPAN  = 13'sd2880;
  localparam logic signed [31:0] ROUND_HALF = 32'sd512;
  localparam logic [10:0]        SCORE_MAX  = 11'd1024;

  typedef struct packed {
    logic        pair_ok;
    logic        s_zero;
    logic        angle_neg;
    logic        first_on_top;
    logic [15:0] mid_x;
    logic [15:0] mid_y;
    logic [15:0] mean_length;
  } side_t;

  typedef struct packed {
    logic        pair_ok;
    logic        target_ok;
    logic [10:0] score;
    logic        first_on_top;
    logic [15:0] mid_x;
    logic [15:0] mid_y;
    logic [15:0] mean_length;
  } res_t;

endpackage

`default_nettype wire

// ===== design/lbps_if.sv =====
`default_nettype none

interface lbps_pair_if;
  logic               valid;
  logic               ready;
  logic [15:0]        first_cx;
  logic [15:0]        first_cy;
  logic [15:0]        first_w;
  logic [15:0]        first_h;
  logic signed [11:0] first_angle;
  logic [15:0]        second_cx;
  logic [15:0]        second_cy;
  logic [15:0]        second_w;
  logic [15:0]        second_h;
  logic signed [11:0] second_angle;

  modport source (
    output valid, first_cx, first_cy, first_w, first_h, first_angle,
           second_cx, second_cy, second_w, second_h, second_angle,
    input  ready
  );
  modport sink (
    input  valid, first_cx, first_cy, first_w, first_h, first_angle,
           second_cx, second_cy, second_w, second_h, second_angle,
    output ready
  );
endinterface

interface lbps_result_if;
  logic        valid;
  logic        ready;
  logic        pair_ok;
  logic        target_ok;
  logic [10:0] score;
  logic        first_on_top;
  logic [15:0] mid_x;
  logic [15:0] mid_y;
  logic [15:0] mean_length;

  modport source (
    output valid, pair_ok, target_ok, score, first_on_top, mid_x, mid_y, mean_length,
    input  ready
  );
  modport sink (
    input  valid, pair_ok, target_ok, score, first_on_top, mid_x, mid_y, mean_length,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/lbps_div_cell.sv =====
`default_nettype none

// One restoring-division step: brings in the next dividend bit, emits one quotient bit.
module lbps_div_cell #(
  parameter int unsigned DenW = 14,
  parameter int unsigned QuoW = 29
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [DenW-1:0] rem_i,
  input  wire logic [QuoW-1:0] quo_i,
  input  wire logic [DenW-1:0] den_i,
  output logic      [DenW-1:0] rem_o,
  output logic      [QuoW-1:0] quo_o,
  output logic      [DenW-1:0] den_o
);

  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            ge;
  logic [DenW-1:0] rem_d, rem_q;
  logic [QuoW-1:0] quo_d, quo_q;
  logic [DenW-1:0] den_q;

  always_comb begin
    trial = {rem_i, quo_i[QuoW-1]};
    ge    = trial >= {1'b0, den_i};
    diff  = trial - {1'b0, den_i};
    rem_d = ge ? diff[DenW-1:0] : trial[DenW-1:0];
    // dividend bits shift out the top while quotient bits shift in below
    quo_d = {quo_i[QuoW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      den_q <= den_i;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign den_o = den_q;

endmodule

`default_nettype wire

// ===== design/lbps_divider.sv =====
`default_nettype none

// Pipelined divider, one cell per quotient bit. The quotient must fit in QuoW bits.
module lbps_divider #(
  parameter int unsigned DenW = 14,
  parameter int unsigned QuoW = 29
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [DenW+QuoW-1:0] dividend_i,
  input  wire logic [DenW-1:0]      divisor_i,
  output logic      [QuoW-1:0]      quo_o,
  output logic      [DenW-1:0]      rem_o
);

  logic [DenW-1:0] rem_c [QuoW+1];
  logic [QuoW-1:0] quo_c [QuoW+1];
  logic [DenW-1:0] den_c [QuoW+1];

  assign rem_c[0] = dividend_i[DenW+QuoW-1:QuoW];
  assign quo_c[0] = dividend_i[QuoW-1:0];
  assign den_c[0] = divisor_i;

  for (genvar g = 0; g < QuoW; g++) begin : g_cell
    lbps_div_cell #(.DenW(DenW), .QuoW(QuoW)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .rem_i (rem_c[g]),
      .quo_i (quo_c[g]),
      .den_i (den_c[g]),
      .rem_o (rem_c[g+1]),
      .quo_o (quo_c[g+1]),
      .den_o (den_c[g+1])
    );
  end

  assign quo_o = quo_c[QuoW];
  assign rem_o = rem_c[QuoW];

endmodule

`default_nettype wire

// ===== design/light_bar_pair_scorer.sv =====
// Channel   | Dir | Carries
// pair_i    | in  | two bar rectangles (center, size, angle)
// result_o  | out | pair/target flags, score, order, midpoint, mean length
// cfg_*_i   | in  | register writes, no read-back
//
// One pair per cycle sustained while the skid stage is empty; the front stages
// feed three 29-cell division chains (one quotient bit per cell).
// Reset (async, active low) clears the valid chain and the output and skid valids; config takes reset values.
// A stalled result sits in the output register; one more result fits in the skid
// stage, and pair_i.ready drops only while the skid stage is full.
`default_nettype none

module light_bar_pair_scorer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  lbps_pair_if.sink                              pair_i,
  lbps_result_if.source                          result_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [lbps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [lbps_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned QW = lbps_pkg::QUO_W;
  localparam int unsigned AW = lbps_pkg::ANG_DEN_W;
  localparam int unsigned LW = lbps_pkg::LEN_DEN_W;
  localparam int unsigned VW = lbps_pkg::VRT_DEN_W;

  // ---------------- configuration ----------------
  logic [10:0] angle_limit_q;
  logic [11:0] spacing_ratio_min_q;
  logic [11:0] spacing_ratio_max_q;
  logic [10:0] confidence_floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_limit_q       <= lbps_pkg::ANGLE_LIMIT_RST;
      spacing_ratio_min_q <= lbps_pkg::SPACING_RATIO_MIN_RST;
      spacing_ratio_max_q <= lbps_pkg::SPACING_RATIO_MAX_RST;
      confidence_floor_q  <= lbps_pkg::CONFIDENCE_FLOOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lbps_pkg::CFG_ANGLE_LIMIT:       angle_limit_q       <= cfg_wdata_i[10:0];
        lbps_pkg::CFG_SPACING_RATIO_MIN: spacing_ratio_min_q <= cfg_wdata_i;
        lbps_pkg::CFG_SPACING_RATIO_MAX: spacing_ratio_max_q <= cfg_wdata_i;
        lbps_pkg::CFG_CONFIDENCE_FLOOR:  confidence_floor_q  <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic en;
  logic skid_valid_q, skid_valid_d;
  assign en           = !skid_valid_q;
  assign pair_i.ready = en;

  // ---------------- stage 1: lengths, deltas, midpoint ----------------
  logic               v1_q;
  logic [15:0]        s1_len1_q, s1_len2_q, s1_dx_q, s1_dy_q;
  logic [11:0]        s1_dabs_q;
  lbps_pkg::side_t    s1_side_q;
  logic signed [12:0] adiff;
  logic [12:0]        aneg;
  logic [16:0]        sumx, sumy;
  lbps_pkg::side_t    s1_side_d;

  always_comb begin
    adiff = {pair_i.first_angle[11], pair_i.first_angle}
          - {pair_i.second_angle[11], pair_i.second_angle};
    aneg  = -adiff;
    sumx  = {1'b0, pair_i.first_cx} + {1'b0, pair_i.second_cx};
    sumy  = {1'b0, pair_i.first_cy} + {1'b0, pair_i.second_cy};
    s1_side_d              = '0;
    s1_side_d.first_on_top = pair_i.first_cy < pair_i.second_cy;
    s1_side_d.mid_x        = sumx[16:1];
    s1_side_d.mid_y        = sumy[16:1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_len1_q <= (pair_i.first_w > pair_i.first_h) ? pair_i.first_w : pair_i.first_h;
      s1_len2_q <= (pair_i.second_w > pair_i.second_h) ? pair_i.second_w : pair_i.second_h;
      s1_dx_q   <= (pair_i.first_cx > pair_i.second_cx) ? pair_i.first_cx - pair_i.second_cx
                                                        : pair_i.second_cx - pair_i.first_cx;
      s1_dy_q   <= (pair_i.first_cy > pair_i.second_cy) ? pair_i.first_cy - pair_i.second_cy
                                                        : pair_i.second_cy - pair_i.first_cy;
      s1_dabs_q <= adiff[12] ? aneg[11:0] : adiff[11:0];
      s1_side_q <= s1_side_d;
    end
  end

  // ---------------- stage 2: sum of lengths, fold, squares ----------------
  logic               v2_q;
  logic [16:0]        s2_s_q;
  logic signed [12:0] s2_fold_q;
  logic [15:0]        s2_lmax_q, s2_lmin_q, s2_dx_q, s2_dy_q;
  logic [31:0]        s2_dxsq_q, s2_dysq_q;
  lbps_pkg::side_t    s2_side_q;
  logic [16:0]        s2_s_d;
  logic signed [12:0] dsig, dalt;
  lbps_pkg::side_t    s2_side_d;

  always_comb begin
    s2_s_d = {1'b0, s1_len1_q} + {1'b0, s1_len2_q};
    dsig   = $signed({1'b0, s1_dabs_q});
    dalt   = lbps_pkg::FOLD_SPAN - dsig;
    s2_side_d             = s1_side_q;
    s2_side_d.mean_length = s2_s_d[16:1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_s_q    <= s2_s_d;
      s2_fold_q <= (dsig < dalt) ? dsig : dalt;
      s2_lmax_q <= (s1_len1_q > s1_len2_q) ? s1_len1_q : s1_len2_q;
      s2_lmin_q <= (s1_len1_q > s1_len2_q) ? s1_len2_q : s1_len1_q;
      s2_dx_q   <= s1_dx_q;
      s2_dy_q   <= s1_dy_q;
      s2_dxsq_q <= 32'(s1_dx_q) * 32'(s1_dx_q);
      s2_dysq_q <= 32'(s1_dy_q) * 32'(s1_dy_q);
      s2_side_q <= s2_side_d;
    end
  end

  // ---------------- stage 3: window bounds, angle numerator ----------------
  logic               v3_q;
  logic [50:0]        s3_dist2_q;
  logic [28:0]        s3_lo_q, s3_hi_q;
  logic [29:0]        s3_c_q;
  logic               s3_sumb_nz_q, s3_ang_fail_q, s3_off_fail_q, s3_lmax_zero_q;
  logic [15:0]        s3_dy_q, s3_lmin_q;
  logic [18:0]        s3_lden_q;
  logic [10:0]        s3_lim_q;
  logic signed [13:0] s3_an_q;
  lbps_pkg::side_t    s3_side_q;
  logic [12:0]        sumb;
  logic [32:0]        sqsum;
  logic [10:0]        lim;
  lbps_pkg::side_t    s3_side_d;

  always_comb begin
    sumb  = {1'b0, spacing_ratio_min_q} + {1'b0, spacing_ratio_max_q};
    sqsum = {1'b0, s2_dxsq_q} + {1'b0, s2_dysq_q};
    lim   = (angle_limit_q == '0) ? 11'd1 : angle_limit_q;
    s3_side_d        = s2_side_q;
    s3_side_d.s_zero = s2_s_q == '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_dist2_q      <= {sqsum, 18'b0};
      s3_lo_q         <= 29'(spacing_ratio_min_q) * 29'(s2_s_q);
      s3_hi_q         <= 29'(spacing_ratio_max_q) * 29'(s2_s_q);
      s3_c_q          <= 30'(sumb) * 30'(s2_s_q);
      s3_sumb_nz_q    <= sumb != '0;
      s3_ang_fail_q   <= s2_fold_q > $signed({2'b0, angle_limit_q});
      s3_off_fail_q   <= {s2_dx_q, 2'b0} > {1'b0, s2_s_q};
      s3_lmax_zero_q  <= s2_lmax_q == '0;
      s3_dy_q         <= s2_dy_q;
      s3_lmin_q       <= s2_lmin_q;
      s3_lden_q       <= {1'b0, s2_lmax_q, 2'b0} + {3'b0, s2_lmax_q};
      s3_lim_q        <= lim;
      s3_an_q         <= $signed({3'b0, lim}) - $signed({s2_fold_q[12], s2_fold_q});
      s3_side_q       <= s3_side_d;
    end
  end

  // ---------------- stage 4: squared bounds, deviation, angle magnitude ----------------
  logic               v4_q;
  logic [50:0]        s4_dist2_q;
  logic [57:0]        s4_lo2_q, s4_hi2_q;
  logic [29:0]        s4_c_q, s4_dev_q;
  logic               s4_inwin_q, s4_ang_fail_q, s4_off_fail_q, s4_lmax_zero_q;
  logic [15:0]        s4_lmin_q;
  logic [18:0]        s4_lden_q;
  logic [11:0]        s4_amag_q;
  logic [AW-1:0]      s4_aden_q;
  lbps_pkg::side_t    s4_side_q;
  logic [29:0]        t30;
  logic [28:0]        v29;
  logic [13:0]        anneg;
  lbps_pkg::side_t    s4_side_d;

  always_comb begin
    t30   = {4'b0, s3_dy_q, 10'b0};
    v29   = {4'b0, s3_dy_q, 9'b0};
    anneg = -s3_an_q;
    s4_side_d           = s3_side_q;
    s4_side_d.angle_neg = s3_an_q[13];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_dist2_q     <= s3_dist2_q;
      s4_lo2_q       <= 58'(s3_lo_q) * 58'(s3_lo_q);
      s4_hi2_q       <= 58'(s3_hi_q) * 58'(s3_hi_q);
      s4_c_q         <= s3_c_q;
      s4_dev_q       <= (t30 > s3_c_q) ? t30 - s3_c_q : s3_c_q - t30;
      s4_inwin_q     <= s3_sumb_nz_q && (v29 >= s3_lo_q) && (v29 <= s3_hi_q);
      s4_ang_fail_q  <= s3_ang_fail_q;
      s4_off_fail_q  <= s3_off_fail_q;
      s4_lmax_zero_q <= s3_lmax_zero_q;
      s4_lmin_q      <= s3_lmin_q;
      s4_lden_q      <= s3_lden_q;
      s4_amag_q      <= s3_an_q[13] ? anneg[11:0] : s3_an_q[11:0];
      s4_aden_q      <= {1'b0, s3_lim_q, 2'b0} + {3'b0, s3_lim_q};
      s4_side_q      <= s4_side_d;
    end
  end

  // ---------------- stage 5: pair verdict, divider operands ----------------
  logic                 v5_q;
  logic [AW+QW-1:0]     s5_advd_q;
  logic [AW-1:0]        s5_aden_q;
  logic [LW+QW-1:0]     s5_ldvd_q;
  logic [LW-1:0]        s5_lden_q;
  logic [VW+QW-1:0]     s5_vdvd_q;
  logic [VW-1:0]        s5_vden_q;
  lbps_pkg::side_t      s5_side_q;
  logic                 sp_fail;
  logic [29:0]          num;
  logic [31:0]          num3;
  logic [VW-1:0]        c5;
  lbps_pkg::side_t      s5_side_d;

  always_comb begin
    sp_fail = ({7'b0, s4_dist2_q} < s4_lo2_q) || ({7'b0, s4_dist2_q} > s4_hi2_q);
    num     = (s4_c_q > s4_dev_q) ? s4_c_q - s4_dev_q : '0;
    num3    = {1'b0, num, 1'b0} + {2'b0, num};
    c5      = {1'b0, s4_c_q, 2'b0} + {3'b0, s4_c_q};
    s5_side_d         = s4_side_q;
    s5_side_d.pair_ok = !s4_ang_fail_q && !s4_side_q.s_zero && !s4_off_fail_q && !sp_fail;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_advd_q <= {11'b0, s4_amag_q, 20'b0};
      s5_aden_q <= s4_aden_q;
      // a zero length or an empty vertical term divides zero by one
      s5_ldvd_q <= s4_lmax_zero_q ? '0 : {12'b0, s4_lmin_q, 20'b0};
      s5_lden_q <= s4_lmax_zero_q ? LW'(1) : s4_lden_q;
      s5_vdvd_q <= (s4_inwin_q && s4_c_q != '0) ? {10'b0, num3, 20'b0} : '0;
      s5_vden_q <= (s4_inwin_q && s4_c_q != '0) ? c5 : VW'(1);
      s5_side_q <= s5_side_d;
    end
  end

  // ---------------- division chains ----------------
  logic [QW-1:0] aq, lq, vq;
  logic [AW-1:0] arem;

  lbps_divider #(.DenW(AW), .QuoW(QW)) u_div_angle (
    .clk_i(clk_i), .en_i(en), .dividend_i(s5_advd_q), .divisor_i(s5_aden_q),
    .quo_o(aq), .rem_o(arem)
  );
  lbps_divider #(.DenW(LW), .QuoW(QW)) u_div_length (
    .clk_i(clk_i), .en_i(en), .dividend_i(s5_ldvd_q), .divisor_i(s5_lden_q),
    .quo_o(lq), .rem_o()
  );
  lbps_divider #(.DenW(VW), .QuoW(QW)) u_div_vert (
    .clk_i(clk_i), .en_i(en), .dividend_i(s5_vdvd_q), .divisor_i(s5_vden_q),
    .quo_o(vq), .rem_o()
  );

  lbps_pkg::side_t side_pipe_q [QW];
  logic [QW-1:0]   vpipe_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_pipe_q[0] <= s5_side_q;
      for (int i = 1; i < QW; i++) begin
        side_pipe_q[i] <= side_pipe_q[i-1];
      end
    end
  end

  // ---------------- final stage: signed sum of terms ----------------
  logic               vf_q;
  logic signed [31:0] f_sum_q;
  lbps_pkg::side_t    f_side_q;
  logic signed [31:0] aterm;

  always_comb begin
    // floor division for a negative angle numerator
    if (side_pipe_q[QW-1].angle_neg) begin
      aterm = -$signed(32'(aq)) - ((arem != '0) ? 32'sd1 : 32'sd0);
    end else begin
      aterm = $signed(32'(aq));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_sum_q  <= aterm + $signed(32'(lq)) + $signed(32'(vq));
      f_side_q <= side_pipe_q[QW-1];
    end
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      vpipe_q <= '0;
      vf_q    <= 1'b0;
    end else if (en) begin
      v1_q    <= pair_i.valid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      vpipe_q <= {vpipe_q[QW-2:0], v5_q};
      vf_q    <= vpipe_q[QW-1];
    end
  end

  // ---------------- rounding, clamp, output register and skid ----------------
  logic signed [31:0] rnd, sc;
  lbps_pkg::res_t     res;
  lbps_pkg::res_t     out_q, out_d, skid_q, skid_d;
  logic               out_valid_q, out_valid_d;
  logic               f_push;

  always_comb begin
    rnd = f_sum_q + lbps_pkg::ROUND_HALF;
    sc  = rnd >>> 10;
    res.pair_ok      = f_side_q.pair_ok;
    res.first_on_top = f_side_q.first_on_top;
    res.mid_x        = f_side_q.mid_x;
    res.mid_y        = f_side_q.mid_y;
    res.mean_length  = f_side_q.mean_length;
    if (f_side_q.s_zero || sc < 0) begin
      res.score = '0;
    end else if (sc > $signed({21'b0, lbps_pkg::SCORE_MAX})) begin
      res.score = lbps_pkg::SCORE_MAX;
    end else begin
      res.score = sc[10:0];
    end
    res.target_ok = f_side_q.pair_ok && (res.score >= confidence_floor_q);
  end

  always_comb begin
    f_push       = en && vf_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || result_o.ready) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = f_push;
      end
    end else if (f_push) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.pair_ok      = out_q.pair_ok;
  assign result_o.target_ok    = out_q.target_ok;
  assign result_o.score        = out_q.score;
  assign result_o.first_on_top = out_q.first_on_top;
  assign result_o.mid_x        = out_q.mid_x;
  assign result_o.mid_y        = out_q.mid_y;
  assign result_o.mean_length  = out_q.mean_length;

endmodule

`default_nettype wire

// ===== design/lbps_checker.sv =====
`default_nettype none

`include "light_bar_pair_scorer_assert.svh"

module lbps_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        pair_ok_i,
  input wire logic        target_ok_i,
  input wire logic [10:0] score_i,
  input wire logic [15:0] mean_length_i
);

  // a stalled beat stays put
  `LBPS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(score_i) && $stable(mean_length_i))

  `LBPS_ASSERT_NOW(a_target_needs_pair, out_valid_i && target_ok_i, pair_ok_i)

  `LBPS_ASSERT_NOW(a_score_range, out_valid_i, score_i <= 11'd1024)

  // input backpressure only follows an output stall
  `LBPS_ASSERT_NOW(a_ready_drop, !in_ready_i, $past(out_valid_i && !out_ready_i))

endmodule

bind light_bar_pair_scorer lbps_checker u_lbps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (pair_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .pair_ok_i     (result_o.pair_ok),
  .target_ok_i   (result_o.target_ok),
  .score_i       (result_o.score),
  .mean_length_i (result_o.mean_length)
);

`default_nettype wire
